### hw/rtl/ocar_pkg.sv
// Shared types and constants of the one-counter automaton run block.
`default_nettype none

package ocar_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FEED  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } ocar_op_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_INITIAL_STATE = 2'd0;
  localparam logic [1:0] CFG_FINAL_MASK    = 2'd1;

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // One stored edge slot (its valid bit lives in flops of its own)
  typedef struct packed {
    logic [7:0]         sym;
    logic [3:0]         target;
    logic signed [7:0]  delta;
    logic               guarded;
    logic signed [15:0] gval;
    logic               at_most;
  } ocar_edge_t;

  // Classified command handed from front to back
  typedef struct packed {
    ocar_op_e   op;
    logic [7:0] symbol;
    logic       wr_ok;
    logic [3:0] row;
    logic [1:0] slot;
    logic       slot_valid;
    ocar_edge_t edge_data;
  } ocar_cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    ocar_cmd_t cmd;
  } ocar_head_t;

  // One result item
  typedef struct packed {
    logic               accepted;
    logic signed [15:0] counter_value;
    logic               stuck;
    logic               went_negative;
    logic               overflowed;
    logic [3:0]         present_state;
  } ocar_result_t;

endpackage

`default_nettype wire

### hw/rtl/one_counter_automaton_run.sv
// Top level of the one-counter automaton run block.
`default_nettype none

// Runs a one-counter automaton over a stream of items: start a word, feed a
// symbol, or write one edge slot of the table. Every item gives exactly one
// result with the acceptance status of the word so far. Items enter a two-entry
// command queue whenever it has room, so input is taken while a result still
// waits on the output. In the back end a start, an edge write or an unused op
// is done in the idle state; a symbol also needs the evaluate state, since the
// present state's edge row is first read from the slot memories into registers
// and then matched, with the counter added and saturated. The edge table's
// valid bits are cleared by reset, so no clearing pass is needed. Configuration
// writes are always ready and must be issued only while the block is idle.
module one_counter_automaton_run #(
  parameter int unsigned NUM_STATES    = 16,
  parameter int unsigned EDGES         = 4,
  parameter int unsigned COUNTER_WIDTH = 16,
  parameter int unsigned SYMBOL_WIDTH  = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input items
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         symbol_i,
  input  wire logic [3:0]         edge_state_i,
  input  wire logic [1:0]         edge_slot_i,
  input  wire logic               edge_valid_i,
  input  wire logic [3:0]         edge_target_i,
  input  wire logic signed [7:0]  edge_delta_i,
  input  wire logic               edge_guarded_i,
  input  wire logic signed [15:0] guard_value_i,
  input  wire logic               guard_at_most_i,
  // Result items
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    accepted_o,
  output logic signed [15:0]      counter_value_o,
  output logic                    stuck_o,
  output logic                    went_negative_o,
  output logic                    overflowed_o,
  output logic [3:0]              present_state_o,
  // Configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  logic                   push;
  logic                   full;
  logic                   pop;
  ocar_pkg::ocar_cmd_t    cmd;
  ocar_pkg::ocar_head_t   head;
  ocar_pkg::ocar_result_t result;

  assign cfg_ready_o = 1'b1;

  ocar_front #(
    .NUM_STATES   (NUM_STATES),
    .EDGES        (EDGES),
    .SYMBOL_WIDTH (SYMBOL_WIDTH)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .symbol_i        (symbol_i),
    .edge_state_i    (edge_state_i),
    .edge_slot_i     (edge_slot_i),
    .edge_valid_i    (edge_valid_i),
    .edge_target_i   (edge_target_i),
    .edge_delta_i    (edge_delta_i),
    .edge_guarded_i  (edge_guarded_i),
    .guard_value_i   (guard_value_i),
    .guard_at_most_i (guard_at_most_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (cmd)
  );

  ocar_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  ocar_back #(
    .NUM_STATES    (NUM_STATES),
    .EDGES         (EDGES),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign accepted_o      = result.accepted;
  assign counter_value_o = result.counter_value;
  assign stuck_o         = result.stuck;
  assign went_negative_o = result.went_negative;
  assign overflowed_o    = result.overflowed;
  assign present_state_o = result.present_state;

endmodule

`default_nettype wire

### hw/rtl/ocar_front.sv
// Front end: accepts input items and classifies them into commands.
`default_nettype none

module ocar_front #(
  parameter int unsigned NUM_STATES   = 16,
  parameter int unsigned EDGES        = 4,
  parameter int unsigned SYMBOL_WIDTH = 8
) (
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         symbol_i,
  input  wire logic [3:0]         edge_state_i,
  input  wire logic [1:0]         edge_slot_i,
  input  wire logic               edge_valid_i,
  input  wire logic [3:0]         edge_target_i,
  input  wire logic signed [7:0]  edge_delta_i,
  input  wire logic               edge_guarded_i,
  input  wire logic signed [15:0] guard_value_i,
  input  wire logic               guard_at_most_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output ocar_pkg::ocar_cmd_t     cmd_o
);

  // Symbols keep only their low SYMBOL_WIDTH bits (the port carries 8)
  localparam int unsigned SymW    = (SYMBOL_WIDTH < 8) ? SYMBOL_WIDTH : 8;
  localparam logic [7:0]  SymMask = 8'((64'd1 << SymW) - 64'd1);

  logic [7:0] sym_masked;

  assign sym_masked = symbol_i & SymMask;

  // Transaction handshake: take an item whenever the queue has room
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the item
  always_comb begin
    cmd_o                    = '0;
    cmd_o.op                 = ocar_pkg::ocar_op_e'(op_i);
    cmd_o.symbol             = sym_masked;
    cmd_o.wr_ok              = (32'(edge_state_i) < NUM_STATES) && (32'(edge_slot_i) < EDGES);
    cmd_o.row                = edge_state_i;
    cmd_o.slot               = edge_slot_i;
    cmd_o.slot_valid         = edge_valid_i;
    cmd_o.edge_data.sym      = sym_masked;
    cmd_o.edge_data.target   = edge_target_i;
    cmd_o.edge_data.delta    = edge_delta_i;
    cmd_o.edge_data.guarded  = edge_guarded_i;
    cmd_o.edge_data.gval     = guard_value_i;
    cmd_o.edge_data.at_most  = guard_at_most_i;
  end

endmodule

`default_nettype wire

### hw/rtl/ocar_queue.sv
// Short command queue decoupling the front end from the back end.
`default_nettype none

module ocar_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire ocar_pkg::ocar_cmd_t  cmd_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output ocar_pkg::ocar_head_t      head_o
);

  localparam int unsigned Depth = ocar_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ocar_pkg::ocar_cmd_t entry_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o       = (32'(count_q) == Depth);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = entry_q[rd_ptr_q];

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= Depth)
    else $error("command queue holds more than its depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

### hw/rtl/ocar_back.sv
// Back end: edge table, automaton state, counter update and result register.
`default_nettype none

module ocar_back #(
  parameter int unsigned NUM_STATES    = 16,
  parameter int unsigned EDGES         = 4,
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ocar_pkg::ocar_head_t head_i,
  output logic                      pop_o,
  input  wire logic                 cfg_valid_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ocar_pkg::ocar_result_t    result_o
);

  // States are 4 bits wide and slots 2 bits wide, so only these rows and lanes exist
  localparam int unsigned Rows  = (NUM_STATES < 16) ? NUM_STATES : 16;
  localparam int unsigned RowW  = $clog2(Rows);
  localparam int unsigned Lanes = (EDGES < 4) ? EDGES : 4;
  localparam int unsigned LaneW = (Lanes > 1) ? $clog2(Lanes) : 1;
  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned WideW = (CW > 16) ? CW : 16;
  localparam int unsigned SumW  = ((CW > 8) ? CW : 8) + 1;

  localparam logic signed [CW-1:0] CntMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CntMin = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } fsm_e;

  fsm_e                   fsm_q, fsm_d;
  logic [3:0]             state_q, state_d;
  logic signed [CW-1:0]   cnt_q, cnt_d;
  logic                   stuck_q, stuck_d;
  logic                   neg_q, neg_d;
  logic                   ovf_q, ovf_d;
  logic [3:0]             init_q;
  logic [15:0]            mask_q;
  logic [7:0]             feed_sym_q;
  logic                   row_ok_q;
  logic                   out_valid_q;
  ocar_pkg::ocar_result_t res_q, res_d;
  logic                   res_load;
  logic                   out_free;
  logic                   rd_en;
  logic                   wr_en;
  logic [RowW-1:0]        rd_row;
  logic [RowW-1:0]        wr_row;
  logic                   row_ok;

  logic [Lanes-1:0]       valid_q [Rows];
  ocar_pkg::ocar_edge_t   lane_rd [Lanes];
  logic [Lanes-1:0]       lane_vld;
  logic [Lanes-1:0]       hit;
  logic [LaneW-1:0]       sel;
  ocar_pkg::ocar_edge_t   sel_edge;
  logic signed [SumW-1:0] sum;
  logic signed [CW-1:0]   sat_cnt;
  logic                   sat_ovf;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_row   = state_q[RowW-1:0];
  assign row_ok   = (32'(state_q) < Rows);
  assign wr_row   = head_i.cmd.row[RowW-1:0];

  // Guard of one slot against the present counter
  function automatic logic guard_ok(ocar_pkg::ocar_edge_t e, logic signed [CW-1:0] c);
    logic signed [WideW-1:0] cw;
    logic signed [WideW-1:0] gw;
    cw = WideW'(c);
    gw = WideW'($signed(e.gval));
    return !e.guarded || (e.at_most ? (cw <= gw) : (cw > gw));
  endfunction

  // Edge table: one memory lane per slot, one row per source state
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    ocar_pkg::ocar_edge_t lane_mem [Rows];
    ocar_pkg::ocar_edge_t rd_q;
    logic                 vrd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en && (head_i.cmd.slot == 2'(l))) begin
        lane_mem[wr_row] <= head_i.cmd.edge_data;
      end
      if (rd_en) begin
        rd_q  <= lane_mem[rd_row];
        vrd_q <= valid_q[rd_row][l];
      end
    end

    assign lane_rd[l]  = rd_q;
    assign lane_vld[l] = vrd_q;
  end

  // Slot valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '{default: '0};
    end else if (wr_en) begin
      for (int l = 0; l < Lanes; l++) begin
        if (head_i.cmd.slot == 2'(l)) begin
          valid_q[wr_row][l] <= head_i.cmd.slot_valid;
        end
      end
    end
  end

  // Match every slot of the row, lowest matching slot wins
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      hit[l] = row_ok_q && lane_vld[l] && (lane_rd[l].sym == feed_sym_q) &&
               guard_ok(lane_rd[l], cnt_q);
    end
    sel = '0;
    for (int l = Lanes - 1; l >= 0; l--) begin
      if (hit[l]) begin
        sel = LaneW'(l);
      end
    end
    sel_edge = lane_rd[sel];
  end

  // Counter update with saturation
  always_comb begin
    sum     = SumW'(cnt_q) + SumW'($signed(sel_edge.delta));
    sat_ovf = 1'b1;
    if (sum > SumW'(CntMax)) begin
      sat_cnt = CntMax;
    end else if (sum < SumW'(CntMin)) begin
      sat_cnt = CntMin;
    end else begin
      sat_cnt = CW'(sum);
      sat_ovf = 1'b0;
    end
  end

  // Command sequencing and next automaton status
  always_comb begin
    fsm_d    = fsm_q;
    state_d  = state_q;
    cnt_d    = cnt_q;
    stuck_d  = stuck_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    res_load = 1'b0;
    unique case (fsm_q)
      ST_IDLE: begin
        if (head_i.valid && (out_free || head_i.cmd.op == ocar_pkg::OP_FEED)) begin
          pop_o = 1'b1;
          unique case (head_i.cmd.op)
            ocar_pkg::OP_START: begin
              state_d  = init_q;
              cnt_d    = '0;
              stuck_d  = 1'b0;
              neg_d    = 1'b0;
              ovf_d    = 1'b0;
              res_load = 1'b1;
            end
            ocar_pkg::OP_FEED: begin
              rd_en = 1'b1;
              fsm_d = ST_EVAL;
            end
            ocar_pkg::OP_WRITE: begin
              wr_en    = head_i.cmd.wr_ok;
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          res_load = 1'b1;
          fsm_d    = ST_IDLE;
          if (!stuck_q) begin
            if (hit != '0) begin
              state_d = sel_edge.target;
              cnt_d   = sat_cnt;
              ovf_d   = ovf_q || sat_ovf;
              neg_d   = neg_q || sat_cnt[CW-1];
            end else begin
              stuck_d = 1'b1;
            end
          end
        end
      end
      default: begin
        fsm_d = ST_IDLE;
      end
    endcase
  end

  // Result built from the updated status
  always_comb begin
    logic signed [WideW-1:0] cnt_ext;
    cnt_ext              = WideW'(cnt_d);
    res_d.accepted       = (cnt_d == '0) && !neg_d && !stuck_d && mask_q[state_d];
    res_d.counter_value  = cnt_ext[15:0];
    res_d.stuck          = stuck_d;
    res_d.went_negative  = neg_d;
    res_d.overflowed     = ovf_d;
    res_d.present_state  = state_d;
  end

  // State machine, status and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      state_q     <= '0;
      cnt_q       <= '0;
      stuck_q     <= 1'b0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      init_q      <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      row_ok_q    <= 1'b0;
      feed_sym_q  <= '0;
      res_q       <= '0;
    end else begin
      fsm_q   <= fsm_d;
      state_q <= state_d;
      cnt_q   <= cnt_d;
      stuck_q <= stuck_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      if (rd_en) begin
        row_ok_q   <= row_ok;
        feed_sym_q <= head_i.cmd.symbol;
      end
      if (res_load) begin
        res_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ocar_pkg::CFG_INITIAL_STATE: init_q <= cfg_data_i[3:0];
          ocar_pkg::CFG_FINAL_MASK:    mask_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

`ifndef SYNTH
  a_stuck_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stuck_q) |-> $past(fsm_q == ST_EVAL))
    else $error("stuck flag set outside symbol evaluation");

  a_frozen_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stuck_q && !(pop_o && head_i.cmd.op == ocar_pkg::OP_START)) |=> $stable(cnt_q))
    else $error("counter moved while word is stuck");

  a_eval_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_EVAL) |-> ($past(fsm_q == ST_EVAL) ||
                            $past(pop_o && head_i.cmd.op == ocar_pkg::OP_FEED)))
    else $error("evaluation entered without a symbol command");
`endif

endmodule

`default_nettype wire
